### hdl/hlsrgb_pkg.sv
// ----------------------------------------------------------------------------
// hlsrgb_pkg
// Shared types, constants and the hue profile function of the HLS to RGB
// converter.
// ----------------------------------------------------------------------------
package hlsrgb_pkg;

  typedef logic [8:0]  hue_t;
  typedef logic [13:0] lvl4_t;
  typedef logic [19:0] chan_val_t;

  typedef struct packed {
    logic en3;
    logic en4;
    logic en5;
  } adv_t;

  localparam hue_t        HueFull    = 9'd360;
  localparam logic [17:0] HueBias    = 18'd33120;
  localparam logic [30:0] HueRecip   = 31'd11651;
  localparam int unsigned HueShift   = 22;
  localparam logic [7:0]  PctMax     = 8'd100;
  localparam logic [6:0]  PctHalf    = 7'd50;
  localparam logic [5:0]  Segment    = 6'd60;
  localparam hue_t        PlateauEnd = 9'd180;
  localparam hue_t        FallEnd    = 9'd240;
  localparam hue_t        OffRed     = 9'd0;
  localparam hue_t        OffGreen   = 9'd120;
  localparam hue_t        OffBlue    = 9'd240;
  localparam logic [44:0] LevelRecip = 45'd29205779;
  localparam int unsigned LevelShift = 36;

  function automatic logic [5:0] chan_factor(hue_t hue, hue_t off);
    hue_t       t;
    logic [5:0] f;
    if (hue >= off) begin
      t = hue - off;
    end else begin
      t = 9'(10'(hue) + 10'(HueFull) - 10'(off));
    end
    priority if (t < 9'(Segment)) begin
      f = t[5:0];
    end else if (t < PlateauEnd) begin
      f = Segment;
    end else if (t < FallEnd) begin
      f = 6'(FallEnd - t);
    end else begin
      f = 6'd0;
    end
    return f;
  endfunction

endpackage

### hdl/hlsrgb_chan.sv
// ----------------------------------------------------------------------------
// hlsrgb_chan
// One color channel: hue profile factor, channel value over the common
// denominator, and scaling to an 8-bit level by reciprocal multiplication.
// ----------------------------------------------------------------------------
module hlsrgb_chan #(
  parameter logic [8:0] OFFSET = 9'd0
) (
  input  logic                  clk_i,
  input  hlsrgb_pkg::adv_t      adv_i,
  input  hlsrgb_pkg::hue_t      hue_i,
  input  hlsrgb_pkg::lvl4_t     m4_i,
  input  hlsrgb_pkg::lvl4_t     span_i,
  output logic [7:0]            level_o
);

  logic [5:0]            fac_q;
  hlsrgb_pkg::chan_val_t val_d, val_q;
  logic [44:0]           prod;
  logic [7:0]            level_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.en3) begin
      fac_q <= hlsrgb_pkg::chan_factor(hue_i, OFFSET);
    end
  end

  assign val_d = 20'(20'(m4_i) * 20'(hlsrgb_pkg::Segment)) + 20'(20'(fac_q) * 20'(span_i));

  always_ff @(posedge clk_i) begin
    if (adv_i.en4) begin
      val_q <= val_d;
    end
  end

  assign prod = 45'(val_q) * hlsrgb_pkg::LevelRecip;

  always_ff @(posedge clk_i) begin
    if (adv_i.en5) begin
      level_q <= 8'(prod >> hlsrgb_pkg::LevelShift);
    end
  end

  assign level_o = level_q;

endmodule

### hdl/hls_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hls_to_rgb_converter
// HLS to RGB color conversion, five-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one color word per cycle while the output is not stalled and returns
// its red, green and blue levels from stage five. Stage one wraps the hue
// by reciprocal multiplication and forms the saturation product, stage two
// finishes the hue remainder and the lower level and span, stage three picks
// each channel's profile factor, stage four forms the channel value and stage
// five scales it to 8 bits. Each stage advances on its own whenever the stage
// after it is empty or moving, so a stall at the output fills bubbles before
// it pushes back on the input.
module hls_to_rgb_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [15:0] hue_degrees_i,
  input  logic [7:0]  lightness_pct_i,
  input  logic [7:0]  saturation_pct_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  red_level_o,
  output logic [7:0]  green_level_o,
  output logic [7:0]  blue_level_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  hlsrgb_pkg::adv_t adv;

  logic [17:0] hue_biased;
  logic [16:0] u_d, u_q;
  logic [30:0] quot_prod;
  logic [7:0]  quot_d, quot_q;
  logic [6:0]  l_clamp, s_clamp, l_min;
  logic [12:0] ls_d, ls_q;
  logic [6:0]  l_q;

  hlsrgb_pkg::hue_t  hue_d, hue_q;
  hlsrgb_pkg::lvl4_t m4_d, m4_q, span_d, span_q;
  hlsrgb_pkg::lvl4_t m4_3_q, span_3_q;

  assign en5 = !v5_q || !stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign stall_o = !en1;
  assign valid_o = v5_q;

  assign adv.en3 = en3;
  assign adv.en4 = en4;
  assign adv.en5 = en5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  assign hue_biased = 18'($signed(hue_degrees_i)) + hlsrgb_pkg::HueBias;
  assign u_d        = hue_biased[16:0];
  assign quot_prod  = 31'(u_d) * hlsrgb_pkg::HueRecip;
  assign quot_d     = 8'(quot_prod >> hlsrgb_pkg::HueShift);

  assign l_clamp = (lightness_pct_i > hlsrgb_pkg::PctMax) ? 7'(hlsrgb_pkg::PctMax)
                                                          : lightness_pct_i[6:0];
  assign s_clamp = (saturation_pct_i > hlsrgb_pkg::PctMax) ? 7'(hlsrgb_pkg::PctMax)
                                                           : saturation_pct_i[6:0];
  assign l_min   = (l_clamp > hlsrgb_pkg::PctHalf) ? 7'(7'(hlsrgb_pkg::PctMax) - l_clamp)
                                                   : l_clamp;
  assign ls_d    = 13'(s_clamp) * 13'(l_min);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      u_q    <= u_d;
      quot_q <= quot_d;
      l_q    <= l_clamp;
      ls_q   <= ls_d;
    end
  end

  assign hue_d  = 9'(u_q - 17'(quot_q) * 17'(hlsrgb_pkg::HueFull));
  assign m4_d   = 14'(14'(l_q) * 14'(hlsrgb_pkg::PctMax)) - 14'(ls_q);
  assign span_d = {ls_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en2) begin
      hue_q  <= hue_d;
      m4_q   <= m4_d;
      span_q <= span_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      m4_3_q   <= m4_q;
      span_3_q <= span_q;
    end
  end

  hlsrgb_chan #(.OFFSET(hlsrgb_pkg::OffRed)) u_red (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .hue_i   (hue_q),
    .m4_i    (m4_3_q),
    .span_i  (span_3_q),
    .level_o (red_level_o)
  );

  hlsrgb_chan #(.OFFSET(hlsrgb_pkg::OffGreen)) u_green (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .hue_i   (hue_q),
    .m4_i    (m4_3_q),
    .span_i  (span_3_q),
    .level_o (green_level_o)
  );

  hlsrgb_chan #(.OFFSET(hlsrgb_pkg::OffBlue)) u_blue (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .hue_i   (hue_q),
    .m4_i    (m4_3_q),
    .span_i  (span_3_q),
    .level_o (blue_level_o)
  );

endmodule

### hdl/hlsrgb_chk.sv
// ----------------------------------------------------------------------------
// hlsrgb_chk
// Port-level checks of the HLS to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hlsrgb_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [7:0]  red_level_o,
  input logic [7:0]  green_level_o,
  input logic [7:0]  blue_level_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !valid_o)
    else $error("output word valid after reset");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("input stalled while output is empty");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) ##1 !stall_i ##1 !stall_i ##1 !stall_i ##1 !stall_i |=> valid_o)
    else $error("accepted word did not reach the output in five cycles");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(red_level_o) && $stable(green_level_o)
                              && $stable(blue_level_o)))
    else $error("stalled output word changed");

endmodule

bind hls_to_rgb_converter hlsrgb_chk u_hlsrgb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (valid_i),
  .stall_o       (stall_o),
  .valid_o       (valid_o),
  .stall_i       (stall_i),
  .red_level_o   (red_level_o),
  .green_level_o (green_level_o),
  .blue_level_o  (blue_level_o)
);
